@@ src/podo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// podo_pkg: shared types and constants for the planar odometry integrator
// Request structs, angle table and fixed-point constants.
// ----------------------------------------------------------------------------
package podo_pkg;

  typedef struct packed {
    logic signed [15:0] vel_fwd;
    logic signed [15:0] vel_side;
    logic signed [15:0] vel_turn;
    logic [15:0]        elapsed;
  } podo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] echo_fwd;
    logic signed [15:0] echo_side;
    logic signed [15:0] echo_turn;
  } podo_out_t;

  localparam int unsigned AngTableLen = 24;
  localparam logic signed [33:0] CordicInvGain = 34'sd652032874;
  localparam logic [17:0] RadToBam = 18'd166886;

  function automatic logic [29:0] ang_entry(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0:  r = 30'd536870912;
        5'd1:  r = 30'd316933406;
        5'd2:  r = 30'd167458907;
        5'd3:  r = 30'd85004756;
        5'd4:  r = 30'd42667331;
        5'd5:  r = 30'd21354465;
        5'd6:  r = 30'd10679838;
        5'd7:  r = 30'd5340245;
        5'd8:  r = 30'd2670163;
        5'd9:  r = 30'd1335087;
        5'd10: r = 30'd667544;
        5'd11: r = 30'd333772;
        5'd12: r = 30'd166886;
        5'd13: r = 30'd83443;
        5'd14: r = 30'd41722;
        5'd15: r = 30'd20861;
        5'd16: r = 30'd10430;
        5'd17: r = 30'd5215;
        5'd18: r = 30'd2608;
        5'd19: r = 30'd1304;
        5'd20: r = 30'd652;
        5'd21: r = 30'd326;
        5'd22: r = 30'd163;
        5'd23: r = 30'd81;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/podo_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// podo_cordic: iterative rotation-mode cordic
// One micro-rotation per cycle on a binary angle; cosine and sine in Q4.30.
// ----------------------------------------------------------------------------
module podo_cordic #(
  parameter int unsigned Steps = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        angle_i,
  output logic                    done_o,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);

  localparam int unsigned NumIter = (Steps > podo_pkg::AngTableLen) ?
                                    podo_pkg::AngTableLen : Steps;

  logic               busy_q, busy_d;
  logic [4:0]         idx_q, idx_d;
  logic               neg_q, neg_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic               done_q, done_d;
  logic signed [33:0] dx, dy, ang, za;

  assign dx  = y_q >>> idx_q;
  assign dy  = x_q >>> idx_q;
  assign ang = {4'd0, podo_pkg::ang_entry(idx_q)};
  assign za  = {{2{angle_i[31]}}, angle_i};

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = 5'd0;
      x_d    = podo_pkg::CordicInvGain;
      y_d    = '0;
      if (za > 34'sd1073741824) begin
        z_d = za - 34'sd2147483648; neg_d = 1'b1;
      end else if (za < -34'sd1073741824) begin
        z_d = za + 34'sd2147483648; neg_d = 1'b1;
      end else begin
        z_d = za; neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - ang;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + ang;
      end
      idx_d = idx_q + 5'd1;
      if (idx_q == 5'(NumIter - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule
`default_nettype wire

@@ src/podo_serial_mult.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// podo_serial_mult: bit-serial signed multiplier
// Shift-add over the multiplier bits, one bit per cycle, top bit weighted negative.
// ----------------------------------------------------------------------------
module podo_serial_mult #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 17
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [AW-1:0]  a_i,
  input  wire logic signed [BW-1:0]  b_i,
  output logic                       done_o,
  output logic signed [AW+BW-1:0]    prod_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(BW + 1);

  logic                 busy_q;
  logic [CW-1:0]        cnt_q;
  logic signed [PW-1:0] a_q;
  logic [BW-1:0]        b_q;
  logic signed [PW-1:0] acc_q;
  logic                 done_q;
  logic                 last;

  assign last = (cnt_q == CW'(BW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= last ? acc_q - a_q : acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ src/planar_odometry_integrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_odometry_integrator: dead-reckoning pose integrator
// Rotates body velocity by heading, integrates position and heading,
// and reports pose with the yaw quaternion.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | request   | in_valid_i, in_ready_o, in_req_i
// out     | result    | out_valid_o, out_ready_i, out_req_o
//
// one request at a time; each request runs a cordic pass, eight serial
// multiplies on one shared 51-by-33-bit shift-add multiplier and a second
// cordic pass, then loads the output register and returns to idle.
// reset clears the pose to zero. a finished result waits in the output
// register; the next request is taken while it waits, and its result
// cannot overwrite the waiting one.
// ----------------------------------------------------------------------------
module planar_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire podo_pkg::podo_in_t   in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output podo_pkg::podo_out_t       out_req_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCs1   = 4'd1;
  localparam logic [3:0] StM1    = 4'd2;
  localparam logic [3:0] StM2    = 4'd3;
  localparam logic [3:0] StM3    = 4'd4;
  localparam logic [3:0] StM4    = 4'd5;
  localparam logic [3:0] StMx    = 4'd6;
  localparam logic [3:0] StMy    = 4'd7;
  localparam logic [3:0] StMt    = 4'd8;
  localparam logic [3:0] StMh    = 4'd9;
  localparam logic [3:0] StCs2   = 4'd10;
  localparam logic [3:0] StWait  = 4'd11;

  logic [3:0]          state_q;
  logic                go_q;
  podo_pkg::podo_in_t  req_q;
  logic signed [31:0]  x_acc_q, y_acc_q;
  logic [31:0]         heading_acc_q;
  logic signed [33:0]  c_q, s_q;
  logic signed [50:0]  p_q;
  logic signed [50:0]  rx_q, ry_q;
  logic                out_valid_q;
  podo_pkg::podo_out_t out_q;

  logic               cs_start, cs_done;
  logic [31:0]        cs_angle;
  logic signed [33:0] cs_cos, cs_sin;
  logic               m_start, m_done;
  logic signed [50:0] m_a;
  logic signed [32:0] m_b;
  logic signed [83:0] m_prod;
  logic signed [83:0] hdg_round;

  podo_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .angle_i(cs_angle),
    .done_o(cs_done), .cos_o(cs_cos), .sin_o(cs_sin)
  );

  podo_serial_mult #(.AW(51), .BW(33)) u_mult (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .done_o(m_done), .prod_o(m_prod)
  );

  assign cs_start = go_q && (state_q == StCs1 || state_q == StCs2);
  assign cs_angle = (state_q == StCs2) ? {1'b0, heading_acc_q[31:1]} : heading_acc_q;
  assign m_start  = go_q && state_q != StCs1 && state_q != StCs2 && state_q != StIdle
                    && state_q != StWait;
  assign hdg_round = m_prod + 84'sd32768;

  always_comb begin
    m_a = '0;
    m_b = '0;
    case (state_q)
      StM1: begin m_a = 51'(c_q); m_b = 33'(req_q.vel_fwd); end
      StM2: begin m_a = 51'(s_q); m_b = 33'(req_q.vel_side); end
      StM3: begin m_a = 51'(s_q); m_b = 33'(req_q.vel_fwd); end
      StM4: begin m_a = 51'(c_q); m_b = 33'(req_q.vel_side); end
      StMx: begin m_a = rx_q; m_b = 33'({1'b0, req_q.elapsed}); end
      StMy: begin m_a = ry_q; m_b = 33'({1'b0, req_q.elapsed}); end
      StMt: begin m_a = 51'(req_q.vel_turn); m_b = 33'({1'b0, req_q.elapsed}); end
      StMh: begin m_a = p_q; m_b = 33'({1'b0, podo_pkg::RadToBam}); end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [83:0] prod);
    logic signed [83:0] d;
    logic signed [84:0] r;
    begin
      d = (prod + (84'sd1 <<< 41)) >>> 42;
      r = 85'(a) + 85'(d);
      if (r > 85'sd2147483647) r = 85'sd2147483647;
      if (r < -85'sd2147483648) r = -85'sd2147483648;
      return r[31:0];
    end
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] r;
    begin
      r = (35'(v) + 35'sd32768) >>> 16;
      if (r > 35'sd16384) r = 35'sd16384;
      if (r < -35'sd16384) r = -35'sd16384;
      return r[15:0];
    end
  endfunction

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      go_q          <= 1'b0;
      x_acc_q       <= '0;
      y_acc_q       <= '0;
      heading_acc_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      go_q <= (state_q == StIdle && in_valid_i) || cs_done || m_done;
      if (out_valid_q && out_ready_i && state_q != StWait) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StCs1;
        StCs1: if (cs_done) state_q <= StM1;
        StM1: if (m_done) state_q <= StM2;
        StM2: if (m_done) state_q <= StM3;
        StM3: if (m_done) state_q <= StM4;
        StM4: if (m_done) state_q <= StMx;
        StMx: if (m_done) begin
          x_acc_q <= sat_add(x_acc_q, m_prod);
          state_q <= StMy;
        end
        StMy: if (m_done) begin
          y_acc_q <= sat_add(y_acc_q, m_prod);
          state_q <= StMt;
        end
        StMt: if (m_done) state_q <= StMh;
        StMh: if (m_done) begin
          heading_acc_q <= heading_acc_q + hdg_round[47:16];
          state_q <= StCs2;
        end
        StCs2: if (cs_done) state_q <= StWait;
        StWait: if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) req_q <= in_req_i;
    if (state_q == StCs1 && cs_done) begin
      c_q <= cs_cos; s_q <= cs_sin;
    end
    if (m_done) begin
      case (state_q)
        StM1: p_q <= m_prod[50:0];
        StM2: rx_q <= p_q - m_prod[50:0];
        StM3: p_q <= m_prod[50:0];
        StM4: ry_q <= p_q + m_prod[50:0];
        StMt: p_q <= m_prod[50:0];
        default: p_q <= p_q;
      endcase
    end
    if (state_q == StWait && (!out_valid_q || out_ready_i)) begin
      out_q.pos_x     <= x_acc_q;
      out_q.pos_y     <= y_acc_q;
      out_q.heading   <= heading_acc_q[31:16];
      out_q.quat_z    <= to_q14(cs_sin);
      out_q.quat_w    <= to_q14(cs_cos);
      out_q.echo_fwd  <= req_q.vel_fwd;
      out_q.echo_side <= req_q.vel_side;
      out_q.echo_turn <= req_q.vel_turn;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped under stall");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cs_start && m_start)) else $error("two units started");

endmodule
`default_nettype wire
